@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds in the same cycle as its trigger.
`define KMDS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A property whose consequence is checked in the cycle after its trigger.
`define KMDS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/kmds_pkg.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce scanner package
// Shared constants, command codes and the event batch handed to the serializer.
// ----------------------------------------------------------------------------
package kmds_pkg;

  localparam int SAMPLE_WIDTH = 8;
  localparam int DEF_ROWS = 8;
  localparam int DEF_COLS = 8;
  localparam logic [7:0] THRESHOLD_RESET = 8'd5;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_LOAD = 1'b1
  } kmds_cmd_t;

  typedef struct packed {
    logic [2:0]                        row;
    logic [SAMPLE_WIDTH-1:0]           mask;
    logic [SAMPLE_WIDTH-1:0]           pressed;
    logic [SAMPLE_WIDTH-1:0][7:0]      codes;
  } kmds_batch_t;

endpackage

@@ src/key_matrix_debounce_scanner.sv @@
// The first event of a scan passes the row update stage, the serializer's held batch
// and its output register. Items are accepted one per cycle while in_stall is low.
// For scans with events the serializer sets the rate: one event per cycle unless stalled.
// Reset clears the row valid flags, so every memory row reads as zero until written.
// No clearing pass is needed after reset; the threshold returns to 5.
// ----------------------------------------------------------------------------
// Key matrix debounce scanner
// Debounces a scanned key matrix with per-key counters held in row memories
// and emits press and release events carrying keymap codes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_matrix_debounce_scanner #(
  parameter int ROWS = kmds_pkg::DEF_ROWS,
  parameter int COLS = kmds_pkg::DEF_COLS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [2:0] row,
  input  logic [2:0] column,
  input  logic [7:0] column_bits,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_row,
  output logic [2:0] event_column,
  output logic [7:0] event_code,
  output logic       is_press,
  output logic       last
);
  import kmds_pkg::*;

  logic [7:0]  threshold;
  logic        in_accept;
  logic        ser_free;
  logic        batch_push;
  kmds_batch_t batch;

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  kmds_row_update #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_row_update (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .command    (command),
    .row        (row),
    .column     (column),
    .column_bits(column_bits),
    .key_code   (key_code),
    .threshold  (threshold),
    .ser_free   (ser_free),
    .busy       (in_stall),
    .batch_push (batch_push),
    .batch      (batch)
  );

  kmds_event_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .batch_push  (batch_push),
    .batch       (batch),
    .ser_free    (ser_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_row   (event_row),
    .event_column(event_column),
    .event_code  (event_code),
    .is_press    (is_press),
    .last        (last)
  );

  `KMDS_ASSERT_NOW(a_push_when_free, batch_push, ser_free, "batch pushed into busy serializer")
  `KMDS_ASSERT_NOW(a_code_nonzero, out_valid, event_code != 8'd0, "event with zero key code")
  `KMDS_ASSERT_NEXT(a_events_contiguous, out_valid && !out_stall && !last, out_valid,
                    "gap inside a row's events")

endmodule

@@ src/kmds_row_update.sv @@
// ----------------------------------------------------------------------------
// Row update stage
// Reads the debounce state and keymap rows, updates all keys (scan) or one
// code (load), writes back, forwards a row written in the same cycle as read.
// ----------------------------------------------------------------------------
module kmds_row_update #(
  parameter int ROWS = kmds_pkg::DEF_ROWS,
  parameter int COLS = kmds_pkg::DEF_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  logic                 command,
  input  logic [2:0]           row,
  input  logic [2:0]           column,
  input  logic [7:0]           column_bits,
  input  logic [7:0]           key_code,
  input  logic [7:0]           threshold,
  input  logic                 ser_free,
  output logic                 busy,
  output logic                 batch_push,
  output kmds_pkg::kmds_batch_t batch
);
  import kmds_pkg::*;

  localparam int NC = (COLS < SAMPLE_WIDTH) ? COLS : SAMPLE_WIDTH;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW = NC * 10;

  logic [SW-1:0]        st_mem [ROWS];
  logic [NC-1:0][7:0]   km_mem [ROWS];
  logic [ROWS-1:0]      st_vld;
  logic [ROWS-1:0]      km_vld;

  logic                 s1_valid;
  kmds_cmd_t            s1_cmd;
  logic                 s1_row_ok;
  logic                 s1_col_ok;
  logic [2:0]           s1_row;
  logic [RW-1:0]        s1_ridx;
  logic [2:0]           s1_col;
  logic [7:0]           s1_bits;
  logic [7:0]           s1_code;
  logic                 s1_st_ok;
  logic                 s1_km_ok;
  logic                 s1_fwd_st;
  logic                 s1_fwd_km;
  logic [SW-1:0]        st_rd;
  logic [NC-1:0][7:0]   km_rd;
  logic [SW-1:0]        fw_st;
  logic [NC-1:0][7:0]   fw_km;

  logic [SW-1:0]        st_eff;
  logic [NC-1:0][7:0]   km_eff;
  logic [SW-1:0]        st_next;
  logic [NC-1:0][7:0]   km_next;
  logic [NC-1:0]        ev_mask;
  logic                 s1_go;
  logic                 st_we;
  logic                 km_we;
  logic [RW-1:0]        in_ridx;
  logic                 in_row_ok;
  logic                 in_col_ok;

  assign in_ridx   = RW'(row);
  assign in_row_ok = 32'(row) < ROWS;
  assign in_col_ok = 32'(column) < NC;

  always_comb begin
    logic       smp;
    logic       stb;
    logic       lst;
    logic [7:0] cnt;
    logic [7:0] cnt_n;
    logic       fire;
    st_eff  = s1_fwd_st ? fw_st : (s1_st_ok ? st_rd : '0);
    km_eff  = s1_fwd_km ? fw_km : (s1_km_ok ? km_rd : '0);
    st_next = st_eff;
    km_next = km_eff;
    ev_mask = '0;
    for (int c = 0; c < NC; c++) begin
      smp = s1_bits[c];
      stb = st_eff[c];
      lst = st_eff[NC + c];
      cnt = st_eff[2*NC + 8*c +: 8];
      if (smp == lst) begin
        cnt_n = (cnt < threshold) ? cnt + 8'd1 : cnt;
      end else begin
        cnt_n = 8'd0;
      end
      fire = (cnt_n >= threshold) && (stb != smp);
      st_next[c]               = fire ? smp : stb;
      st_next[NC + c]          = smp;
      st_next[2*NC + 8*c +: 8] = cnt_n;
      ev_mask[c]               = fire && (km_eff[c] != 8'd0);
      if (s1_col == 3'(c)) begin
        km_next[c] = s1_code;
      end
    end
  end

  always_comb begin
    batch         = '0;
    batch.row     = s1_row;
    batch.mask    = SAMPLE_WIDTH'(ev_mask);
    batch.pressed = s1_bits;
    for (int c = 0; c < NC; c++) begin
      batch.codes[c] = km_eff[c];
    end
  end

  assign st_we      = s1_valid && s1_row_ok && (s1_cmd == CMD_SCAN);
  assign km_we      = s1_valid && s1_row_ok && s1_col_ok && (s1_cmd == CMD_LOAD);
  assign s1_go      = s1_valid && ((ev_mask == '0) || !st_we || ser_free);
  assign busy       = s1_valid && !s1_go;
  assign batch_push = s1_go && st_we && (ev_mask != '0);

  always_ff @(posedge clk) begin
    if (in_accept && in_row_ok) begin
      st_rd <= st_mem[in_ridx];
      km_rd <= km_mem[in_ridx];
    end
    if (s1_go && st_we) begin
      st_mem[s1_ridx] <= st_next;
      fw_st           <= st_next;
    end
    if (s1_go && km_we) begin
      km_mem[s1_ridx] <= km_next;
      fw_km           <= km_next;
    end
    if (in_accept) begin
      s1_cmd    <= kmds_cmd_t'(command);
      s1_row_ok <= in_row_ok;
      s1_col_ok <= in_col_ok;
      s1_row    <= row;
      s1_ridx   <= in_ridx;
      s1_col    <= column;
      s1_bits   <= column_bits;
      s1_code   <= key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      st_vld    <= '0;
      km_vld    <= '0;
      s1_st_ok  <= 1'b0;
      s1_km_ok  <= 1'b0;
      s1_fwd_st <= 1'b0;
      s1_fwd_km <= 1'b0;
    end else begin
      if (s1_go && st_we) begin
        st_vld[s1_ridx] <= 1'b1;
      end
      if (s1_go && km_we) begin
        km_vld[s1_ridx] <= 1'b1;
      end
      if (in_accept) begin
        s1_valid  <= 1'b1;
        s1_st_ok  <= in_row_ok && st_vld[in_ridx];
        s1_km_ok  <= in_row_ok && km_vld[in_ridx];
        s1_fwd_st <= s1_go && st_we && (s1_ridx == in_ridx);
        s1_fwd_km <= s1_go && km_we && (s1_ridx == in_ridx);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/kmds_event_serializer.sv @@
// ----------------------------------------------------------------------------
// Event serializer
// Holds the events of one scanned row and sends them out one per transaction
// in ascending column order through a registered output.
// ----------------------------------------------------------------------------
module kmds_event_serializer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  batch_push,
  input  kmds_pkg::kmds_batch_t batch,
  output logic                  ser_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            event_row,
  output logic [2:0]            event_column,
  output logic [7:0]            event_code,
  output logic                  is_press,
  output logic                  last
);
  import kmds_pkg::*;

  kmds_batch_t             held;
  logic [SAMPLE_WIDTH-1:0] mask;
  logic [SAMPLE_WIDTH-1:0] low_bit;
  logic [SAMPLE_WIDTH-1:0] mask_rest;
  logic [2:0]              low_idx;
  logic                    out_load;

  assign low_bit   = mask & (~mask + SAMPLE_WIDTH'(1));
  assign mask_rest = mask & ~low_bit;
  assign out_load  = !out_valid || !out_stall;
  assign ser_free  = (mask == '0) || ((mask_rest == '0) && out_load);

  always_comb begin
    low_idx = 3'd0;
    for (int c = SAMPLE_WIDTH - 1; c >= 0; c--) begin
      if (mask[c]) begin
        low_idx = 3'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch_push) begin
      held <= batch;
    end
    if (out_load && (mask != '0)) begin
      event_row    <= held.row;
      event_column <= low_idx;
      event_code   <= held.codes[low_idx];
      is_press     <= held.pressed[low_idx];
      last         <= (mask_rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= (mask != '0);
      end
      if (batch_push) begin
        mask <= batch.mask;
      end else if (out_load && (mask != '0)) begin
        mask <= mask_rest;
      end
    end
  end

endmodule

@@ sim/key_matrix_debounce_scanner_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce scanner testbench
// Sends scan and keymap load transactions with random gaps and output stalls.
// The expected key state is tracked alongside the block, and each press or
// release event is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module key_matrix_debounce_scanner_test;
  import kmds_pkg::*;

  localparam int NROWS = DEF_ROWS;
  localparam int NCOLS = DEF_COLS;
  localparam int SCAN_COLS = (NCOLS < SAMPLE_WIDTH) ? NCOLS : SAMPLE_WIDTH;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0] row;
    logic [2:0] column;
    logic [7:0] code;
    logic       press;
    logic       final_flag;
  } key_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       command = CMD_SCAN;
  logic [2:0] row = 3'd0;
  logic [2:0] column = 3'd0;
  logic [7:0] column_bits = 8'd0;
  logic [7:0] key_code = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] event_row;
  logic [2:0] event_column;
  logic [7:0] event_code;
  logic       is_press;
  logic       last;

  logic       stable_q [NROWS][NCOLS];
  logic       sample_q [NROWS][NCOLS];
  logic [7:0] count_q  [NROWS][NCOLS];
  logic [7:0] keymap_q [NROWS][NCOLS];
  logic [7:0] threshold_q = THRESHOLD_RESET;

  key_event_t  awaited_events[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          steady_flow = 1'b0;

  key_matrix_debounce_scanner dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .row         (row),
    .column      (column),
    .column_bits (column_bits),
    .key_code    (key_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_row   (event_row),
    .event_column(event_column),
    .event_code  (event_code),
    .is_press    (is_press),
    .last        (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events outstanding", $time, awaited_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    key_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual row %0d column %0d code %0d",
                 $time, event_row, event_column, event_code);
        mismatches++;
      end else begin
        want = awaited_events.pop_front();
        check_field("event_row", want.row, event_row);
        check_field("event_column", want.column, event_column);
        check_field("event_code", want.code, event_code);
        check_field("is_press", want.press, is_press);
        check_field("last", want.final_flag, last);
      end
    end
  end

  function automatic void update_key_state(kmds_cmd_t cmd, logic [2:0] r, logic [2:0] c,
                                           logic [7:0] bits, logic [7:0] code);
    key_event_t batch[$];
    key_event_t ev;
    logic       hit;
    if (r >= NROWS) return;
    if (cmd == CMD_LOAD) begin
      if (c < NCOLS) keymap_q[r][c] = code;
      return;
    end
    for (int k = 0; k < SCAN_COLS; k++) begin
      hit = bits[k];
      if (hit == sample_q[r][k]) begin
        if (count_q[r][k] < threshold_q) count_q[r][k] = count_q[r][k] + 8'd1;
      end else begin
        count_q[r][k] = 8'd0;
        sample_q[r][k] = hit;
      end
      if (count_q[r][k] >= threshold_q && stable_q[r][k] != hit) begin
        stable_q[r][k] = hit;
        if (keymap_q[r][k] != 8'd0) begin
          ev.row = r;
          ev.column = 3'(k);
          ev.code = keymap_q[r][k];
          ev.press = hit;
          ev.final_flag = 1'b0;
          batch.push_back(ev);
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].final_flag = 1'b1;
    foreach (batch[i]) awaited_events.push_back(batch[i]);
  endfunction

  task automatic send_item(kmds_cmd_t cmd, logic [2:0] r, logic [2:0] c,
                           logic [7:0] bits, logic [7:0] code);
    int unsigned gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    row <= r;
    column <= c;
    column_bits <= bits;
    key_code <= code;
    do @(posedge clk); while (in_stall);
    update_key_state(cmd, r, c, bits, code);
    @(negedge clk);
  endtask

  task automatic scan_row(logic [2:0] r, logic [7:0] bits);
    send_item(CMD_SCAN, r, 3'($urandom), bits, 8'($urandom));
  endtask

  task automatic load_key(logic [2:0] r, logic [2:0] c, logic [7:0] code);
    send_item(CMD_LOAD, r, c, 8'($urandom), code);
  endtask

  task automatic wait_for_events();
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold_q = value;
  endtask

  // A zero threshold accepts every change on the scan that brings it.
  task automatic test_zero_threshold();
    write_threshold(8'd0);
    load_key(3'd0, 3'd0, 8'hFF);
    load_key(3'd0, 3'd7, 8'h01);
    load_key(3'd0, 3'd3, 8'h00);
    load_key(3'd0, 3'd5, 8'h80);
    scan_row(3'd0, 8'hFF);
    scan_row(3'd0, 8'h00);
    wait_for_events();
  endtask

  // Counts keep climbing under a high threshold, so a lower one takes effect at once.
  task automatic test_count_saturation();
    write_threshold(8'd255);
    load_key(3'd1, 3'd0, 8'h11);
    load_key(3'd1, 3'd6, 8'hEE);
    repeat (4) scan_row(3'd1, 8'h41);
    wait_for_events();
    write_threshold(8'd2);
    scan_row(3'd1, 8'h41);
    wait_for_events();
  endtask

  task automatic test_contact_bounce();
    write_threshold(8'd3);
    load_key(3'd7, 3'd2, 8'h3C);
    scan_row(3'd7, 8'h04);
    scan_row(3'd7, 8'h00);
    repeat (4) scan_row(3'd7, 8'h04);
    repeat (4) scan_row(3'd7, 8'h00);
    wait_for_events();
  endtask

  task automatic test_keymap_fill();
    for (int r = 0; r < NROWS; r++) begin
      for (int c = 0; c < NCOLS; c++) begin
        load_key(3'(r), 3'(c), 8'($urandom_range(1, 255)));
      end
    end
  endtask

  // Mostly settled row patterns held long enough to pass the debounce count,
  // mixed with keymap rewrites, stray scans and bounces.
  task automatic run_random_phase(logic [7:0] threshold, int unsigned items);
    int unsigned sent;
    int unsigned reps;
    logic [2:0]  r;
    logic [7:0]  target;
    wait_for_events();
    write_threshold(threshold);
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0: begin
          load_key(3'($urandom), 3'($urandom),
                   ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom));
          sent++;
        end
        1: begin
          scan_row(3'($urandom), 8'($urandom));
          sent++;
        end
        default: begin
          r = 3'($urandom);
          target = 8'($urandom);
          if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < SCAN_COLS; k++) target[k] = ~stable_q[r][k];
          end
          if ($urandom_range(0, 4) == 0) begin
            scan_row(r, 8'($urandom));
            sent++;
          end
          reps = threshold_q + 1 + $urandom_range(0, 1);
          repeat (reps) scan_row(r, target);
          sent += reps;
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    test_keymap_fill();
    run_random_phase(8'd1, 70);
    run_random_phase(8'd0, 70);
    run_random_phase(8'($urandom_range(2, 6)), 70);
    run_random_phase(8'd4, 70);
    wait_for_events();
    steady_flow = 1'b1;
    run_random_phase(8'd2, 60);
  endtask

  initial begin
    for (int r = 0; r < NROWS; r++) begin
      for (int c = 0; c < NCOLS; c++) begin
        stable_q[r][c] = 1'b0;
        sample_q[r][c] = 1'b0;
        count_q[r][c] = 8'd0;
        keymap_q[r][c] = 8'd0;
      end
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_zero_threshold();
    test_count_saturation();
    test_contact_bounce();
    test_random_traffic();
    wait_for_events();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/kmds_pkg.sv
src/kmds_row_update.sv
src/kmds_event_serializer.sv
src/key_matrix_debounce_scanner.sv
sim/key_matrix_debounce_scanner_test.sv
